### sv/rfr_pkg.sv
package rfr_pkg;

   // default payload limit per frame
   localparam int unsigned MAX_PAYLOAD_DEF = 64;

   // csr register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUMP_ADDR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CTRL_ADDR = 1'b1;

   localparam logic [7:0] PUMP_ADDR_RST = 8'd96;
   localparam logic [7:0] CTRL_ADDR_RST = 8'd16;

   // frame framing bytes
   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] SYNC_BYTE  = 8'hA5;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   // event kinds
   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_FRAME   = 2'd1;
   localparam logic [1:0] EV_ABORT   = 2'd2;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  frame_dest;
      logic [7:0]  frame_source;
      logic [7:0]  frame_action;
      logic [7:0]  frame_length;
      logic        sum_matches;
      logic [15:0] received_sum;
   } rfr_result_type;

endpackage

### sv/rfr_input_stage.sv
module rfr_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);
   import rfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // free, or emptying this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

### sv/rfr_parser.sv
module rfr_parser #(
   parameter int unsigned MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             pump_address,
   input  logic [7:0]             controller_address,
   output logic                   has_result,
   output rfr_pkg::rfr_result_type result
);
   import rfr_pkg::*;

   localparam logic [3:0] PH_HUNT = 4'd0;
   localparam logic [3:0] PH_A5   = 4'd1;
   localparam logic [3:0] PH_ZERO = 4'd2;
   localparam logic [3:0] PH_DST  = 4'd3;
   localparam logic [3:0] PH_SRC  = 4'd4;
   localparam logic [3:0] PH_ACT  = 4'd5;
   localparam logic [3:0] PH_LEN  = 4'd6;
   localparam logic [3:0] PH_DATA = 4'd7;
   localparam logic [3:0] PH_SUMH = 4'd8;
   localparam logic [3:0] PH_SUML = 4'd9;

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [3:0]  phase_ff,  phase_in;
   logic [7:0]  dest_ff,   dest_in;
   logic [7:0]  source_ff, source_in;
   logic [7:0]  action_ff, action_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  taken_ff,  taken_in;
   logic [15:0] sum_ff,    sum_in;
   logic [7:0]  sumh_ff,   sumh_in;

   logic        id_known;
   logic [15:0] sum_add;
   logic [7:0]  taken_inc;
   logic [15:0] got_sum;

   assign id_known  = (rx_byte == pump_address) || (rx_byte == controller_address);
   assign sum_add   = sum_ff + 16'(rx_byte);
   assign taken_inc = taken_ff + 8'd1;
   assign got_sum   = {sumh_ff, rx_byte};

   always_comb begin
      phase_in   = phase_ff;
      dest_in    = dest_ff;
      source_in  = source_ff;
      action_in  = action_ff;
      length_in  = length_ff;
      taken_in   = taken_ff;
      sum_in     = sum_ff;
      sumh_in    = sumh_ff;
      has_result = 1'b0;
      result     = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            phase_in = (rx_byte == START_BYTE) ? PH_A5 : PH_HUNT;
         end
         PH_A5: begin
            if (rx_byte == SYNC_BYTE) begin
               dest_in   = '0;
               source_in = '0;
               action_in = '0;
               length_in = '0;
               taken_in  = '0;
               sumh_in   = '0;
               sum_in    = 16'(SYNC_BYTE);
               phase_in  = PH_ZERO;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_ZERO: begin
            phase_in = (rx_byte == ZERO_BYTE) ? PH_DST : PH_HUNT;
         end
         PH_DST: begin
            if (id_known) begin
               dest_in  = rx_byte;
               sum_in   = sum_add;
               phase_in = PH_SRC;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_SRC: begin
            if (id_known) begin
               source_in = rx_byte;
               sum_in    = sum_add;
               phase_in  = PH_ACT;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_ACT: begin
            action_in = rx_byte;
            sum_in    = sum_add;
            phase_in  = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            taken_in  = '0;
            sum_in    = sum_add;
            phase_in  = (rx_byte == 8'd0) ? PH_SUMH : PH_DATA;
         end
         PH_DATA: begin
            has_result = 1'b1;
            if (taken_ff >= MAX_LEN || taken_ff >= length_ff) begin
               result.event_kind    = EV_ABORT;
               result.payload_index = taken_ff;
               result.frame_dest    = dest_ff;
               result.frame_source  = source_ff;
               result.frame_action  = action_ff;
               result.frame_length  = length_ff;
               phase_in             = PH_HUNT;
            end else begin
               result.event_kind    = EV_PAYLOAD;
               result.payload_byte  = rx_byte;
               result.payload_index = taken_ff;
               sum_in               = sum_add;
               taken_in             = taken_inc;
               phase_in             = (taken_inc == length_ff) ? PH_SUMH : PH_DATA;
            end
         end
         PH_SUMH: begin
            sumh_in  = rx_byte;
            phase_in = PH_SUML;
         end
         PH_SUML: begin
            has_result          = 1'b1;
            result.event_kind   = EV_FRAME;
            result.frame_dest   = dest_ff;
            result.frame_source = source_ff;
            result.frame_action = action_ff;
            result.frame_length = length_ff;
            result.sum_matches  = (got_sum == sum_ff);
            result.received_sum = got_sum;
            phase_in            = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         dest_ff   <= '0;
         source_ff <= '0;
         action_ff <= '0;
         length_ff <= '0;
         taken_ff  <= '0;
         sum_ff    <= '0;
         sumh_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         dest_ff   <= dest_in;
         source_ff <= source_in;
         action_ff <= action_in;
         length_ff <= length_in;
         taken_ff  <= taken_in;
         sum_ff    <= sum_in;
         sumh_ff   <= sumh_in;
      end
   end

`ifndef ASSERT_OFF
   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      has_result |-> (phase_ff == PH_DATA || phase_ff == PH_SUML))
      else $error("result outside payload or checksum phase");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (taken_ff < length_ff && taken_ff <= MAX_LEN))
      else $error("payload count out of range");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_SUML |=> phase_ff == PH_HUNT)
      else $error("no return to hunt after frame");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(sum_ff))
      else $error("parser state moved without a byte");
`endif

endmodule

### sv/rs485_frame_receiver.sv
// rs485 frame receiver
//
// bytes from the serial line come in on the req_ channel, one per request.
// the block hunts for frames FF A5 00 dest src action len payload sumh suml.
// dest and src must match one of the two device ids held in csr registers
// (index 0 pump address, index 1 controller address); a mismatch drops the
// frame silently. each payload byte gives a result with its index, the last
// checksum byte gives a frame result with the header fields and the sum
// check, and a payload past the length limit gives an abort result.
// results leave on the rsp_ channel.
//
// a request is first held in the input register and is then parsed into the
// result register when the parser steps, so a result passes through both
// registers after the request is taken. one request per cycle is taken in
// steady state while the output register is free; the parse step is one small state update per byte.
// while a result waits in the output register, bytes that give no result
// still go through; a byte that gives a result waits in the input register
// until rsp_ready frees the output register, and req_ready is low meanwhile.
// reset clears the parse state, the queues and the device ids to defaults.
module rs485_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte requests
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   // results
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_event_kind,
   output logic [7:0]                      rsp_payload_byte,
   output logic [7:0]                      rsp_payload_index,
   output logic [7:0]                      rsp_frame_dest,
   output logic [7:0]                      rsp_frame_source,
   output logic [7:0]                      rsp_frame_action,
   output logic [7:0]                      rsp_frame_length,
   output logic                            rsp_sum_matches,
   output logic [15:0]                     rsp_received_sum,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);
   import rfr_pkg::*;

   logic           hold_valid;
   logic [7:0]     hold_byte;
   logic           take;
   logic           has_result;
   rfr_result_type step_result;

   logic [7:0]     pump_addr_ff;
   logic [7:0]     ctrl_addr_ff;

   logic           out_valid_ff, out_valid_in;
   rfr_result_type out_ff;
   logic           out_free;
   logic           load_out;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_addr_ff <= PUMP_ADDR_RST;
         ctrl_addr_ff <= CTRL_ADDR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PUMP_ADDR: pump_addr_ff <= csr_data;
            CSR_CTRL_ADDR: ctrl_addr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rfr_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .hold_valid  (hold_valid),
      .hold_byte   (hold_byte)
   );

   rfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock              (clock),
      .reset              (reset),
      .step               (take),
      .rx_byte            (hold_byte),
      .pump_address       (pump_addr_ff),
      .controller_address (ctrl_addr_ff),
      .has_result         (has_result),
      .result             (step_result)
   );

   // output register is free when empty or being drained this cycle
   assign out_free     = !out_valid_ff || rsp_ready;
   assign take         = hold_valid && (!has_result || out_free);
   assign load_out     = take && has_result;
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_ff.event_kind;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_dest    = out_ff.frame_dest;
   assign rsp_frame_source  = out_ff.frame_source;
   assign rsp_frame_action  = out_ff.frame_action;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_sum_matches   = out_ff.sum_matches;
   assign rsp_received_sum  = out_ff.received_sum;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("waiting result changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EV_PAYLOAD || rsp_event_kind == EV_FRAME
                     || rsp_event_kind == EV_ABORT))
      else $error("bad event kind");
`endif

endmodule
